// ===== design/assert_macros.svh =====
// Assertion macros for the top-level design file, clocked on clock, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/prrt_pkg.sv =====
// Shared constants, codes and control types of the port refcount rate table.
`timescale 1ns / 1ps
package prrt_pkg;

   localparam int PORT_BITS      = 16;
   localparam int COUNT_BITS     = 16;
   localparam int RATE_FRAC_BITS = 16;

   localparam int OP_BITS        = 1;
   localparam int CONV_PORT_BITS = 16;
   localparam int SVC_BITS       = 16;
   localparam int PRIOR_BITS     = 16;
   localparam int RATE_OUT_BITS  = 17;
   localparam int STATUS_BITS    = 2;

   localparam int REQ_DATA_BITS  = 32;
   localparam int RSP_DATA_BITS  = 40;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - PRIOR_BITS - RATE_OUT_BITS;

   localparam int TABLE_DEPTH    = 1 << PORT_BITS;
   localparam int RATE_BITS      = RATE_FRAC_BITS + 1;
   localparam int REM_BITS       = SVC_BITS + 1;
   localparam int WIDE_BITS      = (COUNT_BITS > SVC_BITS) ? COUNT_BITS : SVC_BITS;
   localparam int STEP_BITS      = $clog2(RATE_FRAC_BITS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [RATE_BITS-1:0]  RATE_ONE  = {1'b1, {RATE_FRAC_BITS{1'b0}}};
   localparam logic [STEP_BITS-1:0]  STEP_LAST = STEP_BITS'(RATE_FRAC_BITS - 1);

   typedef enum logic [OP_BITS-1:0] {
      OP_NEW    = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STS_OK        = 2'd0,
      STS_ABSENT    = 2'd1,
      STS_ZERO_SVC  = 2'd2,
      STS_SATURATED = 2'd3
   } status_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic lookup;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_div;
   } sts_type;

endpackage

// ===== design/port_refcount_rate_table.sv =====
// Top level of the per-port live-conversation count table with same-port rate.
//
//   channel  | direction | tdata (low bit up)                    | tuser
//   req_     | in        | conv_port[15:0], service_count[31:16] | operation[0]
//   rsp_     | out       | prior_count[15:0], port_rate[32:16]   | status[1:0]
//
// After reset the table is swept to zero, one entry a cycle, with req_tready low over
// all 65536 entries. An item then passes through accept, table read, 16 steps of the
// radix-2 divider and result load when a rate fraction is computed, and skips the divider
// otherwise. A result held by rsp_tready low stalls only the next result load;
// a new beat is taken while the previous result waits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module port_refcount_rate_table (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // conv_port, service_count
   input  logic [prrt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // operation
   input  logic [prrt_pkg::OP_BITS-1:0]       req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // prior_count, port_rate, zero fill
   output logic [prrt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // status
   output logic [prrt_pkg::STATUS_BITS-1:0]   rsp_tuser
);

   prrt_pkg::cmd_type cmd;
   prrt_pkg::sts_type sts;

   logic [prrt_pkg::RATE_OUT_BITS-1:0] rsp_rate;
   logic [prrt_pkg::PRIOR_BITS-1:0]    rsp_prior;
   logic                               rsp_absent;
   logic                               rsp_err;

   prrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   prrt_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   assign rsp_rate   = rsp_tdata[prrt_pkg::PRIOR_BITS +: prrt_pkg::RATE_OUT_BITS];
   assign rsp_prior  = rsp_tdata[prrt_pkg::PRIOR_BITS-1:0];
   assign rsp_absent = (rsp_tuser == prrt_pkg::STS_ABSENT);
   assign rsp_err    = rsp_absent || (rsp_tuser == prrt_pkg::STS_ZERO_SVC);

   `ASSERT_NOW(a_no_rate_on_error, rsp_tvalid && rsp_err, rsp_rate == '0)
   `ASSERT_NOW(a_absent_prior_zero, rsp_tvalid && rsp_absent, rsp_prior == '0)
   `ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)

endmodule

// ===== design/prrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module prrt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== design/prrt_ctrl.sv =====
// Controller: clearing pass, beat sequencing, divider step count and result valid.
`timescale 1ns / 1ps
module prrt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  prrt_pkg::sts_type sts,
   output prrt_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                      state_ff, state_in;
   logic [prrt_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.load     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.lookup   = (state_ff == ST_LOOKUP);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.finish   = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            step_in  = '0;
            state_in = sts.need_div ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            step_in = step_ff + 1'b1;
            if (step_ff == prrt_pkg::STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/prrt_dpath.sv =====
// Datapath: count table, update logic, restoring divider and result registers.
`timescale 1ns / 1ps
module prrt_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  prrt_pkg::cmd_type                    cmd,
   output prrt_pkg::sts_type                    sts,
   input  logic [prrt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [prrt_pkg::OP_BITS-1:0]         req_tuser,
   output logic [prrt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic [prrt_pkg::STATUS_BITS-1:0]     rsp_tuser
);

   logic [prrt_pkg::PORT_BITS-1:0]     clr_addr_ff, clr_addr_in;
   prrt_pkg::op_type                   op_ff;
   logic [prrt_pkg::PORT_BITS-1:0]     idx_ff;
   logic [prrt_pkg::SVC_BITS-1:0]      svc_ff;
   logic [prrt_pkg::COUNT_BITS-1:0]    prior_ff;
   logic [prrt_pkg::REM_BITS-1:0]      rem_ff;
   logic [prrt_pkg::RATE_BITS-1:0]     quo_ff;
   prrt_pkg::status_type               status_ff;
   logic [prrt_pkg::PRIOR_BITS-1:0]    rsp_prior_ff;
   logic [prrt_pkg::RATE_OUT_BITS-1:0] rsp_rate_ff;
   prrt_pkg::status_type               rsp_status_ff;

   logic [prrt_pkg::COUNT_BITS-1:0]    rd_data;
   logic                               wr_en;
   logic [prrt_pkg::PORT_BITS-1:0]     wr_addr;
   logic [prrt_pkg::COUNT_BITS-1:0]    wr_data;

   logic                               upd_en;
   logic [prrt_pkg::COUNT_BITS-1:0]    upd_val;
   prrt_pkg::status_type               lk_status;
   logic [prrt_pkg::RATE_BITS-1:0]     lk_rate;
   logic                               need_div;
   logic [prrt_pkg::REM_BITS-1:0]      shifted;
   logic [prrt_pkg::REM_BITS-1:0]      svc_ext;
   logic                               take;

   always_comb begin
      upd_en    = 1'b0;
      upd_val   = rd_data;
      lk_status = prrt_pkg::STS_OK;
      lk_rate   = '0;
      need_div  = 1'b0;
      if (op_ff == prrt_pkg::OP_NEW) begin
         if (rd_data != prrt_pkg::COUNT_MAX) begin
            upd_en  = 1'b1;
            upd_val = rd_data + prrt_pkg::COUNT_BITS'(1);
         end else begin
            lk_status = prrt_pkg::STS_SATURATED;
         end
         if (svc_ff == '0) begin
            lk_status = prrt_pkg::STS_ZERO_SVC;
         end else if (prrt_pkg::WIDE_BITS'(rd_data) >= prrt_pkg::WIDE_BITS'(svc_ff)) begin
            lk_rate = prrt_pkg::RATE_ONE;
         end else begin
            need_div = 1'b1;
         end
      end else begin
         if (rd_data == '0) begin
            lk_status = prrt_pkg::STS_ABSENT;
         end else begin
            upd_en  = 1'b1;
            upd_val = rd_data - prrt_pkg::COUNT_BITS'(1);
         end
      end
   end

   // one quotient bit per step; remainder stays below the service count
   assign svc_ext = prrt_pkg::REM_BITS'(svc_ff);
   assign shifted = {rem_ff[prrt_pkg::REM_BITS-2:0], 1'b0};
   assign take    = (shifted >= svc_ext);

   assign sts.clear_last = (clr_addr_ff == '1);
   assign sts.need_div   = need_div;

   assign wr_en   = cmd.clear || (cmd.lookup && upd_en);
   assign wr_addr = cmd.clear ? clr_addr_ff : idx_ff;
   assign wr_data = cmd.clear ? '0 : upd_val;

   assign clr_addr_in = clr_addr_ff + 1'b1;

   prrt_ram #(
      .WIDTH (prrt_pkg::COUNT_BITS),
      .DEPTH (prrt_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.load),
      .rd_addr (req_tdata[prrt_pkg::PORT_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= prrt_pkg::op_type'(req_tuser);
         idx_ff <= req_tdata[prrt_pkg::PORT_BITS-1:0];
         svc_ff <= req_tdata[prrt_pkg::CONV_PORT_BITS +: prrt_pkg::SVC_BITS];
      end
      if (cmd.lookup) begin
         prior_ff  <= rd_data;
         status_ff <= lk_status;
         quo_ff    <= lk_rate;
         rem_ff    <= prrt_pkg::REM_BITS'(rd_data);
      end
      if (cmd.div_step) begin
         rem_ff <= take ? (shifted - svc_ext) : shifted;
         quo_ff <= {quo_ff[prrt_pkg::RATE_BITS-2:0], take};
      end
      if (cmd.finish) begin
         rsp_prior_ff  <= prrt_pkg::PRIOR_BITS'(prior_ff);
         rsp_rate_ff   <= prrt_pkg::RATE_OUT_BITS'(quo_ff);
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tdata = {{prrt_pkg::RSP_PAD_BITS{1'b0}}, rsp_rate_ff, rsp_prior_ff};
   assign rsp_tuser = rsp_status_ff;

endmodule

// ===== bench/port_refcount_rate_table_tb.sv =====
// Testbench for the per-port live-conversation count table with same-port rate.
`timescale 1ns / 1ps
module port_refcount_rate_table_tb;

   localparam int WATCHDOG_LIMIT = 300000;
   localparam int LONG_HOLD      = 400;

   typedef struct {
      prrt_pkg::op_type op;
      bit [15:0] port;
      bit [15:0] svc;
   } conv_event_type;

   typedef struct {
      bit [15:0]  prior;
      bit [16:0]  rate;
      prrt_pkg::status_type status;
   } conv_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [prrt_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;  // conv_port, service_count
   logic [prrt_pkg::OP_BITS-1:0] req_tuser = '0;        // operation
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [prrt_pkg::RSP_DATA_BITS-1:0] rsp_tdata;       // prior_count, port_rate, zero fill
   logic [prrt_pkg::STATUS_BITS-1:0] rsp_tuser;         // status

   port_refcount_rate_table u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   conv_event_type  pending_events[$];
   conv_result_type expected_results[$];
   bit [15:0]       live_count[bit [15:0]];
   bit [15:0]       hot_ports[12];
   conv_event_type  next_ev;

   int  beats_issued = 0;
   int  beats_taken = 0;
   int  results_checked = 0;
   int  errors = 0;
   int  idle_cycles = 0;
   int  req_gap = 0;
   int  rsp_hold = 0;
   int  status_seen[4] = '{0, 0, 0, 0};
   bit  idle_on = 1'b0;
   bit  long_stall_req = 1'b0;

   // count update and expected result for one event
   function automatic conv_result_type apply_event(conv_event_type ev);
      conv_result_type res;
      bit [15:0] prior;
      bit [47:0] quot;
      prior = live_count.exists(ev.port) ? live_count[ev.port] : 16'd0;
      res.prior = prior;
      res.rate = '0;
      res.status = prrt_pkg::STS_OK;
      if (ev.op == prrt_pkg::OP_NEW) begin
         if (prior != prrt_pkg::COUNT_MAX)
            live_count[ev.port] = prior + 16'd1;
         else
            res.status = prrt_pkg::STS_SATURATED;
         if (ev.svc == 16'd0) begin
            res.status = prrt_pkg::STS_ZERO_SVC;
         end else begin
            quot = (48'(prior) << prrt_pkg::RATE_FRAC_BITS) / 48'(ev.svc);
            res.rate = (quot > 48'(prrt_pkg::RATE_ONE)) ? prrt_pkg::RATE_ONE : quot[16:0];
         end
      end else if (prior == 16'd0) begin
         res.status = prrt_pkg::STS_ABSENT;
      end else begin
         live_count[ev.port] = prior - 16'd1;
      end
      return res;
   endfunction

   task automatic add_event(prrt_pkg::op_type op, bit [15:0] port, bit [15:0] svc);
      conv_event_type ev;
      ev.op = op;
      ev.port = port;
      ev.svc = svc;
      pending_events.push_back(ev);
   endtask

   task automatic add_random_events(int n);
      conv_event_type ev;
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            ev.port = 16'($urandom);
            ev.op = prrt_pkg::op_type'($urandom_range(0, 1));
         end else begin
            ev.port = hot_ports[$urandom_range(0, 11)];
            ev.op = ($urandom_range(0, 99) < 42) ? prrt_pkg::OP_REMOVE : prrt_pkg::OP_NEW;
         end
         pick = $urandom_range(0, 99);
         if (pick < 6)
            ev.svc = 16'd0;
         else if (pick < 35)
            ev.svc = 16'($urandom_range(1, 8));
         else
            ev.svc = 16'($urandom);
         pending_events.push_back(ev);
      end
   endtask

   task automatic drain();
      while (pending_events.size() != 0 || beats_taken != beats_issued
             || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || beats_taken == beats_issued) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 7);
            req_tvalid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            next_ev = pending_events.pop_front();
            req_tdata <= {next_ev.svc, next_ev.port};
            req_tuser <= next_ev.op;
            req_tvalid <= 1'b1;
            beats_issued++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response ready
   always @(negedge clock) begin
      if (long_stall_req) begin
         rsp_hold = LONG_HOLD;
         long_stall_req = 1'b0;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_hold = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      conv_event_type  ev;
      conv_result_type exp_res;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (req_tvalid && req_tready) begin
            ev.op = prrt_pkg::op_type'(req_tuser);
            ev.port = req_tdata[15:0];
            ev.svc = req_tdata[31:16];
            expected_results.push_back(apply_event(ev));
            beats_taken++;
            idle_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            if (expected_results.size() == 0) begin
               $error("result beat with nothing expected: tdata %h tuser %0d",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               exp_res = expected_results.pop_front();
               results_checked++;
               status_seen[rsp_tuser]++;
               if (rsp_tdata[15:0] !== exp_res.prior) begin
                  $error("prior_count expected %0d got %0d", exp_res.prior, rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[32:16] !== exp_res.rate) begin
                  $error("port_rate expected %0d got %0d", exp_res.rate, rsp_tdata[32:16]);
                  errors++;
               end
               if (rsp_tuser !== exp_res.status) begin
                  $error("status expected %0d got %0d", exp_res.status, rsp_tuser);
                  errors++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      hot_ports[0] = 16'h0000;
      hot_ports[1] = 16'hFFFF;
      for (int i = 2; i < 12; i++)
         hot_ports[i] = 16'($urandom);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero service count, rate at and above 1.0, absent removal
      idle_on = 1'b1;
      add_event(prrt_pkg::OP_NEW, 16'h0000, 16'd0);
      add_event(prrt_pkg::OP_NEW, 16'h0000, 16'd1);
      add_event(prrt_pkg::OP_NEW, 16'h0000, 16'hFFFF);
      add_event(prrt_pkg::OP_NEW, 16'h0000, 16'd3);
      add_event(prrt_pkg::OP_NEW, 16'h0000, 16'd2);
      add_event(prrt_pkg::OP_REMOVE, 16'h0000, 16'hFFFF);
      add_event(prrt_pkg::OP_REMOVE, 16'h0000, 16'd0);
      add_event(prrt_pkg::OP_REMOVE, 16'hFFFF, 16'd5);
      add_event(prrt_pkg::OP_NEW, 16'hFFFF, 16'hFFFF);
      add_event(prrt_pkg::OP_NEW, 16'hFFFF, 16'd7);
      add_event(prrt_pkg::OP_REMOVE, 16'hFFFF, 16'd7);
      add_event(prrt_pkg::OP_REMOVE, 16'hFFFF, 16'd7);
      add_event(prrt_pkg::OP_REMOVE, 16'hFFFF, 16'd7);
      add_event(prrt_pkg::OP_NEW, 16'hAAAA, 16'h5555);
      add_event(prrt_pkg::OP_NEW, 16'h5555, 16'hAAAA);
      add_event(prrt_pkg::OP_NEW, 16'h5555, 16'h8000);
      add_event(prrt_pkg::OP_REMOVE, 16'hAAAA, 16'h5555);
      add_event(prrt_pkg::OP_REMOVE, 16'h5555, 16'hAAAA);
      add_event(prrt_pkg::OP_REMOVE, 16'h5555, 16'hAAAA);
      add_event(prrt_pkg::OP_REMOVE, 16'h5555, 16'hAAAA);
      drain();

      // repeated hits on one port over the short zero-service path, then rates
      idle_on = 1'b0;
      for (int i = 0; i < 6; i++)
         add_event(prrt_pkg::OP_NEW, 16'h1234, 16'd0);
      add_event(prrt_pkg::OP_NEW, 16'h1234, 16'hFFFF);
      add_event(prrt_pkg::OP_NEW, 16'h1234, 16'd0);
      add_event(prrt_pkg::OP_NEW, 16'h1234, 16'd1);
      add_event(prrt_pkg::OP_REMOVE, 16'h1234, 16'd9);
      add_event(prrt_pkg::OP_NEW, 16'h1234, 16'd40000);
      add_event(prrt_pkg::OP_NEW, 16'h1234, 16'd40000);
      drain();

      // long response hold-off while requests keep coming
      long_stall_req = 1'b1;
      add_random_events(24);
      drain();

      idle_on = 1'b1;
      add_random_events(664);
      drain();

      idle_on = 1'b0;
      add_random_events(130);
      drain();
      repeat (40) @(posedge clock);

      $display("covered %0d request beats, %0d results checked, incl. a long result hold-off",
               beats_taken, results_checked);
      $display("status mix: ok %0d, absent %0d, zero service %0d, saturated %0d",
               status_seen[prrt_pkg::STS_OK], status_seen[prrt_pkg::STS_ABSENT],
               status_seen[prrt_pkg::STS_ZERO_SVC], status_seen[prrt_pkg::STS_SATURATED]);
      if (errors == 0 && expected_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/prrt_pkg.sv
design/prrt_ram.sv
design/prrt_ctrl.sv
design/prrt_dpath.sv
design/port_refcount_rate_table.sv
bench/port_refcount_rate_table_tb.sv
